### src/ddm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants for the differential drive mixer
// Widths, drive mode codes, register indexes and the divide-by-100 constants.
// ----------------------------------------------------------------------------
package ddm_pkg;

  // field widths
  localparam int CMD_W    = 8;
  localparam int DUTY_W   = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // full duty scale; motor range is this minus min_duty
  localparam int DUTY_FULL_SCALE = 255;
  localparam int PCT_FULL        = 100;

  // shared multiply / divide-by-100 unit
  localparam int MDU_A_W    = 9;   // up to (255 + 255)
  localparam int MDU_B_W    = 8;
  localparam int MDU_P_W    = MDU_A_W + MDU_B_W;
  localparam int MDU_Q_W    = 11;  // quotient up to 1300
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W    = 18;
  // ceil(2^24 / 100); exact for products below about 199000
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(167773);

  // drive mode codes
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY_PCT = 2'd1;

  localparam logic [CFG_DAT_W-1:0] MIN_DUTY_RST     = 8'd100;
  localparam logic [CFG_DAT_W-1:0] MAX_DUTY_PCT_RST = 8'd100;

  // true when a signed percent lies in -100..100 (signed compare)
  function automatic logic in_pct(input logic signed [CMD_W-1:0] v);
    in_pct = (v >= -$signed(CMD_W'(PCT_FULL))) && (v <= $signed(CMD_W'(PCT_FULL)));
  endfunction

  // magnitude of an in-range percent (0..100)
  function automatic logic [6:0] pct_mag(input logic signed [CMD_W-1:0] v);
    logic [CMD_W-1:0] n;
    n = v[CMD_W-1] ? (~v + 1'b1) : v;
    pct_mag = n[6:0];
  endfunction

endpackage

### src/ddm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_if: channel interfaces of the differential drive mixer
// Command, result and configuration write channels, each valid/ready.
// ----------------------------------------------------------------------------

// command channel
interface ddm_cmd_if import ddm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] speed_cmd;
  logic signed [CMD_W-1:0] direction_cmd;
  logic signed [CMD_W-1:0] correction_cmd;

  modport source (output valid, output speed_cmd, output direction_cmd,
                  output correction_cmd, input ready);
  modport sink   (input valid, input speed_cmd, input direction_cmd,
                  input correction_cmd, output ready);
endinterface

// result channel
interface ddm_res_if import ddm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] left_mode;
  logic [DUTY_W-1:0] left_duty;
  logic [MODE_W-1:0] right_mode;
  logic [DUTY_W-1:0] right_duty;

  modport source (output valid, output left_mode, output left_duty,
                  output right_mode, output right_duty, input ready);
  modport sink   (input valid, input left_mode, input left_duty,
                  input right_mode, input right_duty, output ready);
endinterface

// configuration write channel
interface ddm_cfg_if import ddm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/differential_drive_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_mixer: speed / steering / trim mixer for two motors
// Turns one drive command into a mode and PWM duty for each side.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  cmd     | sink   | speed_cmd, direction_cmd, correction_cmd (signed %)
//  res     | source | left_mode, left_duty, right_mode, right_duty
//  cfg     | sink   | index (0 min_duty, 1 max_duty_percent), data
//
//  One command at a time: the next command is taken only once the current
//  item has left the sequencer. Each item uses the shared multiply /
//  divide-by-100 unit 4 or 5 times, 4 when the kept direction is zero.
//  A finished item waits in the output register; the next command is taken
//  meanwhile, and the block holds its last step only if that register is full.
//  Reset (rst, synchronous) restores min_duty and max_duty_percent to 100 and
//  clears the kept direction and correction. cfg is always ready.
// ----------------------------------------------------------------------------
module differential_drive_mixer import ddm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ddm_cmd_if.sink   cmd,
  ddm_res_if.source res,
  ddm_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {S_IDLE, S_TRIM, S_RUN, S_WAIT, S_DONE} state_t;
  typedef enum logic [2:0] {OP_RSIDE, OP_LSIDE, OP_MIX, OP_DLEFT, OP_DRIGHT} op_t;

  state_t state;
  op_t    op;

  logic [CFG_DAT_W-1:0] min_duty;
  logic [CFG_DAT_W-1:0] max_duty_pct;
  logic signed [CMD_W-1:0] kept_dir;
  logic signed [CMD_W-1:0] kept_corr;

  logic [6:0]        speed_mag;
  logic              speed_neg;
  logic [DUTY_W-1:0] lrange, rrange;
  logic [DUTY_W-1:0] lmag, rmag;
  logic              lneg, rneg;
  logic [DUTY_W-1:0] lduty;
  logic [DUTY_W-1:0] rduty;

  logic              out_valid;
  logic [MODE_W-1:0] out_lmode, out_rmode;
  logic [DUTY_W-1:0] out_lduty, out_rduty;

  // shared unit hookup
  logic               mdu_start;
  logic [MDU_A_W-1:0] mdu_a;
  logic [MDU_B_W-1:0] mdu_b;
  logic               mdu_done;
  logic [MDU_Q_W-1:0] mdu_quo;

  ddm_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (mdu_start),
    .a     (mdu_a),
    .b     (mdu_b),
    .done  (mdu_done),
    .quo   (mdu_quo)
  );

  // handshakes
  logic cmd_fire, cfg_fire, res_fire, out_free, load_out;
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign res_fire  = out_valid && res.ready;
  assign out_free  = !out_valid || res.ready;
  assign load_out  = (state == S_DONE) && out_free;

  assign res.valid      = out_valid;
  assign res.left_mode  = out_lmode;
  assign res.left_duty  = out_lduty;
  assign res.right_mode = out_rmode;
  assign res.right_duty = out_rduty;

  // trim: (range / 100) * (100 - |corr|)
  logic [DUTY_W-1:0] range_full;
  logic [1:0]        range_hund;
  logic [6:0]        trim_fac;
  logic [DUTY_W-1:0] range_trim;

  always_comb begin
    range_full = DUTY_W'(DUTY_FULL_SCALE) - min_duty;
    if (range_full >= DUTY_W'(2 * PCT_FULL)) begin
      range_hund = 2'd2;
    end else if (range_full >= DUTY_W'(PCT_FULL)) begin
      range_hund = 2'd1;
    end else begin
      range_hund = 2'd0;
    end
    trim_fac = 7'(PCT_FULL) - pct_mag(kept_corr);
    case (range_hund)
      2'd2:    range_trim = {trim_fac, 1'b0};
      2'd1:    range_trim = {1'b0, trim_fac};
      default: range_trim = '0;
    endcase
  end

  // steering factor: 100 + 2*dir (dir < 0) or 100 - 2*dir (dir > 0)
  logic signed [CMD_W:0] dir2;
  logic signed [CMD_W:0] mix_f;
  logic                  mix_neg;
  logic [CMD_W:0]        mix_abs;
  logic                  dir_neg, dir_zero;

  always_comb begin
    dir_neg  = kept_dir[CMD_W-1];
    dir_zero = (kept_dir == '0);
    dir2     = {kept_dir, 1'b0};
    mix_f    = dir_neg ? ((CMD_W+1)'(PCT_FULL) + dir2) : ((CMD_W+1)'(PCT_FULL) - dir2);
    mix_neg  = mix_f[CMD_W];
    mix_abs  = mix_neg ? (~mix_f + 1'b1) : mix_f;
  end

  // operand select for the shared unit
  always_comb begin
    mdu_a = '0;
    mdu_b = '0;
    unique case (op)
      OP_RSIDE: begin
        mdu_a = MDU_A_W'(rrange);
        mdu_b = MDU_B_W'(speed_mag);
      end
      OP_LSIDE: begin
        mdu_a = MDU_A_W'(lrange);
        mdu_b = MDU_B_W'(speed_mag);
      end
      OP_MIX: begin
        mdu_a = dir_neg ? MDU_A_W'(rmag) : MDU_A_W'(lmag);
        mdu_b = mix_abs[MDU_B_W-1:0];
      end
      OP_DLEFT: begin
        mdu_a = MDU_A_W'(lmag) + MDU_A_W'(min_duty);
        mdu_b = max_duty_pct;
      end
      OP_DRIGHT: begin
        mdu_a = MDU_A_W'(rmag) + MDU_A_W'(min_duty);
        mdu_b = max_duty_pct;
      end
      default: begin
        mdu_a = '0;
        mdu_b = '0;
      end
    endcase
  end

  logic mix_skip;
  assign mix_skip  = (op == OP_MIX) && dir_zero;
  assign mdu_start = (state == S_RUN) && !mix_skip;

  // saturated duty from the unit result
  logic [DUTY_W-1:0] duty_sat;
  assign duty_sat = (mdu_quo > MDU_Q_W'(DUTY_FULL_SCALE)) ? DUTY_W'(DUTY_FULL_SCALE)
                                                         : mdu_quo[DUTY_W-1:0];

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_RSIDE;
      out_valid    <= 1'b0;
      min_duty     <= MIN_DUTY_RST;
      max_duty_pct <= MAX_DUTY_PCT_RST;
      kept_dir     <= '0;
      kept_corr    <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg.index)
          REG_MIN_DUTY:     min_duty     <= cfg.data;
          REG_MAX_DUTY_PCT: max_duty_pct <= cfg.data;
          default: ;
        endcase
      end

      // output register drains unless it is reloaded in the same cycle
      if (res_fire && !load_out) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (in_pct(cmd.speed_cmd)) begin
              speed_mag <= pct_mag(cmd.speed_cmd);
              speed_neg <= cmd.speed_cmd[CMD_W-1];
            end else begin
              speed_mag <= '0;
              speed_neg <= 1'b0;
            end
            if (in_pct(cmd.direction_cmd)) begin
              kept_dir <= cmd.direction_cmd;
            end
            if (in_pct(cmd.correction_cmd)) begin
              kept_corr <= cmd.correction_cmd;
            end
            state <= S_TRIM;
          end
        end

        S_TRIM: begin
          if (kept_corr > 0) begin
            lrange <= range_full;
            rrange <= range_trim;
          end else if (kept_corr < 0) begin
            lrange <= range_trim;
            rrange <= range_full;
          end else begin
            lrange <= range_full;
            rrange <= range_full;
          end
          op    <= OP_RSIDE;
          state <= S_RUN;
        end

        S_RUN: begin
          if (mix_skip) begin
            op <= OP_DLEFT;
          end else begin
            state <= S_WAIT;
          end
        end

        S_WAIT: begin
          if (mdu_done) begin
            state <= S_RUN;
            unique case (op)
              OP_RSIDE: begin
                rmag <= mdu_quo[DUTY_W-1:0];
                rneg <= speed_neg;
                op   <= OP_LSIDE;
              end
              OP_LSIDE: begin
                lmag <= mdu_quo[DUTY_W-1:0];
                lneg <= speed_neg;
                op   <= OP_MIX;
              end
              OP_MIX: begin
                if (dir_neg) begin
                  lmag <= mdu_quo[DUTY_W-1:0];
                  lneg <= rneg ^ mix_neg;
                end else begin
                  rmag <= mdu_quo[DUTY_W-1:0];
                  rneg <= lneg ^ mix_neg;
                end
                op <= OP_DLEFT;
              end
              OP_DLEFT: begin
                lduty <= duty_sat;
                op    <= OP_DRIGHT;
              end
              OP_DRIGHT: begin
                rduty <= duty_sat;
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_DONE: begin
          // load the result once the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            if (lmag == '0) begin
              out_lmode <= MODE_STOP;
              out_lduty <= '0;
            end else begin
              out_lmode <= lneg ? MODE_BACK : MODE_FWD;
              out_lduty <= lduty;
            end
            if (rmag == '0) begin
              out_rmode <= MODE_STOP;
              out_rduty <= '0;
            end else begin
              out_rmode <= rneg ? MODE_BACK : MODE_FWD;
              out_rduty <= rduty;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // unit results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mdu_done |-> (state == S_WAIT))
    else $error("muldiv result outside wait state");

  // an accepted command starts the trim step and blocks further commands
  a_accept_trim: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state == S_TRIM) && !cmd.ready)
    else $error("accepted command did not enter trim");

  // a stopped side always shows zero duty
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.left_mode == MODE_STOP) |-> (res.left_duty == '0))
    else $error("left side stopped with nonzero duty");

  a_stop_zero_r: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.right_mode == MODE_STOP) |-> (res.right_duty == '0))
    else $error("right side stopped with nonzero duty");

  // the idle sequencer leaves the shared unit empty
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mdu_start && !mdu_done)
    else $error("shared unit busy while idle");
`endif

endmodule

### src/ddm_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_muldiv: shared multiply then divide-by-100 unit
// Two-stage pipeline: product, then reciprocal multiply for truncating /100.
// ----------------------------------------------------------------------------
module ddm_muldiv import ddm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MDU_A_W-1:0] a,
  input  logic [MDU_B_W-1:0] b,
  output logic               done,
  output logic [MDU_Q_W-1:0] quo
);

  localparam int SCALED_W = MDU_P_W + RECIP_W;

  logic               v1;
  logic [MDU_P_W-1:0] prod;
  logic [SCALED_W-1:0] scaled;

  // reciprocal multiply; exact over the product range used here
  assign scaled = SCALED_W'(prod) * SCALED_W'(RECIP_K);

  // stage 1: product, stage 2: quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
    prod <= MDU_P_W'(a) * MDU_P_W'(b);
    quo  <= scaled[RECIP_SHIFT +: MDU_Q_W];
  end

endmodule
